[hw/rtl/dawc_pkg.sv]
// ----------------------------------------------------------------------------
// dawc_pkg
// Shared types, constants and codes for the distinct address window counter.
// ----------------------------------------------------------------------------
`default_nettype none

package dawc_pkg;

    localparam int ADDR_W      = 48;
    localparam int TIME_W      = 32;
    localparam int WIN_W       = 16;
    localparam int THR_W       = 8;
    localparam int COUNT_W     = 6;
    localparam int LEVEL_W     = 2;
    localparam int ENTRIES_DEF = 32;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // flag levels
    localparam logic [LEVEL_W-1:0] LVL_NONE     = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_ELEVATED = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_SPAM     = 2'd2;

    // register indexes
    localparam logic [1:0] REG_WINDOW   = 2'd0;
    localparam logic [1:0] REG_ELEVATED = 2'd1;
    localparam logic [1:0] REG_SPAM     = 2'd2;

    // item kinds
    localparam logic ACT_ADVERT = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
        logic [TIME_W-1:0] time_sec;
        logic              pattern_match;
    } t_in_word;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [COUNT_W-1:0] distinct_count;
    } t_out_word;

    typedef struct packed {
        logic [WIN_W-1:0] window_seconds;
        logic [THR_W-1:0] elevated_threshold;
        logic [THR_W-1:0] spam_threshold;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic start_scan;
        logic scan_search;
        logic write_slot;
        logic load_result;
    } t_ctl_cmd;

    typedef struct packed {
        logic scan_done;
        logic is_tick;
        logic is_match;
        logic out_free;
    } t_dp_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SEARCH,
        ST_WRITE,
        ST_COUNT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/dawc_ram.sv]
// ----------------------------------------------------------------------------
// dawc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dawc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/dawc_ctrl.sv]
// ----------------------------------------------------------------------------
// dawc_ctrl
// Sequencer: accept, search scan, slot write, count scan, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module dawc_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire dawc_pkg::t_dp_status  i_status,
    output dawc_pkg::t_ctl_cmd         o_cmd
);
    import dawc_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_START;
                end
            end
            ST_START: begin
                o_cmd.start_scan = 1'b1;
                if (!i_status.is_tick && i_status.is_match) begin
                    o_cmd.scan_search = 1'b1;
                    n_state           = ST_SEARCH;
                end else begin
                    n_state = ST_COUNT;
                end
            end
            ST_SEARCH: begin
                if (i_status.scan_done) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // slot write and count scan launch share this cycle
                o_cmd.write_slot = 1'b1;
                o_cmd.start_scan = 1'b1;
                n_state          = ST_COUNT;
            end
            ST_COUNT: begin
                if (i_status.scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/dawc_datapath.sv]
// ----------------------------------------------------------------------------
// dawc_datapath
// Slot table, clock, scan pipeline, search trackers, counter and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module dawc_datapath #(
    parameter int ENTRIES = dawc_pkg::ENTRIES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire dawc_pkg::t_in_word   i_in_word,
    input  wire dawc_pkg::t_cfg       i_cfg,
    input  wire dawc_pkg::t_ctl_cmd   i_cmd,
    output dawc_pkg::t_dp_status      o_status,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output dawc_pkg::t_out_word       o_out_word
);
    import dawc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int ENT_W = ADDR_W + TIME_W;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    t_in_word          r_item;
    logic [TIME_W-1:0] r_clock;
    logic [ENTRIES-1:0] r_used;

    // scan pipeline
    logic              r_search;
    logic              r_rd_act;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_pv;
    logic [IDX_W-1:0]  r_pidx;

    // search trackers
    logic              r_hit_found;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [TIME_W-1:0] r_hit_seen;
    logic              r_free_found;
    logic [IDX_W-1:0]  r_free_idx;
    logic [IDX_W-1:0]  r_old_idx;
    logic [TIME_W-1:0] r_old_seen;
    logic [COUNT_W-1:0] r_count;

    logic [ENT_W-1:0]  ram_rdata;
    logic [ADDR_W-1:0] ent_addr;
    logic [TIME_W-1:0] ent_seen;
    logic [TIME_W-1:0] ref_time;
    logic              ent_used;
    logic              win_ok;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [TIME_W-1:0] wr_time;
    logic [LEVEL_W-1:0] level;

    dawc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_idx),
        .i_wdata ({r_item.address, wr_time}),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    // window test of the entry coming out of the ram
    always_comb begin
        ent_addr = ram_rdata[TIME_W +: ADDR_W];
        ent_seen = ram_rdata[TIME_W-1:0];
        ent_used = r_used[r_pidx];
        ref_time = r_search ? r_item.time_sec : r_clock;
        win_ok   = (ent_seen <= ref_time) &&
                   ((ref_time - ent_seen) < {{(TIME_W-WIN_W){1'b0}}, i_cfg.window_seconds});
    end

    // slot choice: known address, else first reclaimable, else oldest
    always_comb begin
        wr_en   = i_cmd.write_slot;
        wr_idx  = r_hit_found ? r_hit_idx : (r_free_found ? r_free_idx : r_old_idx);
        wr_time = r_item.time_sec;
        if (r_hit_found && (r_item.time_sec < r_hit_seen)) begin
            wr_time = r_hit_seen;
        end
    end

    // flag level, spam tested first
    always_comb begin
        if ({{(THR_W-COUNT_W){1'b0}}, r_count} >= i_cfg.spam_threshold) begin
            level = LVL_SPAM;
        end else if ({{(THR_W-COUNT_W){1'b0}}, r_count} >= i_cfg.elevated_threshold) begin
            level = LVL_ELEVATED;
        end else begin
            level = LVL_NONE;
        end
    end

    always_comb begin
        o_status.scan_done = r_pv && (r_pidx == LAST);
        o_status.is_tick   = (r_item.action == ACT_TICK);
        o_status.is_match  = r_item.pattern_match;
        o_status.out_free  = !o_out_valid || i_out_ready;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock     <= '0;
            r_used      <= '0;
            r_rd_act    <= 1'b0;
            r_pv        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // clock moves forward on ticks and matching adverts
            if (i_cmd.accept && (i_in_word.action == ACT_TICK || i_in_word.pattern_match)
                && (i_in_word.time_sec >= r_clock)) begin
                r_clock <= i_in_word.time_sec;
            end
            // read issue
            if (i_cmd.start_scan) begin
                r_rd_act <= 1'b1;
            end else if (r_rd_act && (r_rd_idx == LAST)) begin
                r_rd_act <= 1'b0;
            end
            r_pv <= r_rd_act;
            // slot allocation and tick ageing
            if (wr_en) begin
                r_used[wr_idx] <= 1'b1;
            end
            if (r_pv && !r_search && (r_item.action == ACT_TICK) && ent_used && !win_ok) begin
                r_used[r_pidx] <= 1'b0;
            end
            // result word
            if (i_cmd.load_result) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_word;
        end
        if (i_cmd.start_scan) begin
            r_search     <= i_cmd.scan_search;
            r_rd_idx     <= '0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_count      <= '0;
        end else if (r_rd_act && (r_rd_idx != LAST)) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        r_pidx <= r_rd_idx;
        if (r_pv && r_search) begin
            if (!r_hit_found && ent_used && (ent_addr == r_item.address)) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= r_pidx;
                r_hit_seen  <= ent_seen;
            end
            if (!r_free_found && (!ent_used || !win_ok)) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_pidx;
            end
            if ((r_pidx == '0) || (ent_seen < r_old_seen)) begin
                r_old_idx  <= r_pidx;
                r_old_seen <= ent_seen;
            end
        end
        // live count, saturating
        if (r_pv && !r_search && ent_used && win_ok && (r_count != COUNT_MAX)) begin
            r_count <= r_count + 1'b1;
        end
        if (i_cmd.load_result) begin
            o_out_word.level          <= level;
            o_out_word.distinct_count <= r_count;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/distinct_address_window_counter_unit.sv]
// ----------------------------------------------------------------------------
// distinct_address_window_counter_unit
// Counts distinct advertiser addresses seen within a sliding time window.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  in        input      i_in_valid / o_in_ready        i_in_word  (t_in_word)
//  out       output     o_out_valid / i_out_ready      o_out_word (t_out_word)
//  config    input      psel penable pwrite pready     paddr pwdata prdata
//
//  A matching advert runs a search scan, a slot write and a count scan, each
//  scan through the single read port of the slot ram; ticks and unmarked
//  adverts run the count scan only. One item at a time; the result word waits in
//  its own register, and the next item is taken while it waits.
//  Reset is synchronous and needs no clearing pass: slot used bits are flops.
//  A stalled output holds the finished item in its last state until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_address_window_counter_unit #(
    parameter int ENTRIES = dawc_pkg::ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire dawc_pkg::t_in_word            i_in_word,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output dawc_pkg::t_out_word                o_out_word,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dawc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [dawc_pkg::PDATA_W-1:0]  pwdata,
    output logic      [dawc_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);
    import dawc_pkg::*;

    t_cfg       r_cfg;
    t_ctl_cmd   cmd;
    t_dp_status status;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_seconds     <= 16'd60;
            r_cfg.elevated_threshold <= 8'd4;
            r_cfg.spam_threshold     <= 8'd8;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_WINDOW:   r_cfg.window_seconds     <= pwdata[WIN_W-1:0];
                REG_ELEVATED: r_cfg.elevated_threshold <= pwdata[THR_W-1:0];
                REG_SPAM:     r_cfg.spam_threshold     <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            REG_WINDOW:   prdata = {{(PDATA_W-WIN_W){1'b0}}, r_cfg.window_seconds};
            REG_ELEVATED: prdata = {{(PDATA_W-THR_W){1'b0}}, r_cfg.elevated_threshold};
            REG_SPAM:     prdata = {{(PDATA_W-THR_W){1'b0}}, r_cfg.spam_threshold};
            default:      prdata = '0;
        endcase
    end

    dawc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dawc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

[hw/rtl/dawc_checker.sv]
// ----------------------------------------------------------------------------
// dawc_checker
// Port-level checks for the distinct address window counter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module dawc_checker #(
    parameter int ENTRIES = dawc_pkg::ENTRIES_DEF
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire dawc_pkg::t_out_word o_out_word,
    input wire logic                pready
);
    import dawc_pkg::*;

    // a held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // one item at a time
    a_in_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken while busy");

    // level code and count range
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.level == LVL_NONE) || (o_out_word.level == LVL_ELEVATED)
                     || (o_out_word.level == LVL_SPAM))
        else $error("bad level code");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_out_word.distinct_count) <= ENTRIES))
        else $error("count exceeds table size");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind distinct_address_window_counter_unit dawc_checker #(.ENTRIES(ENTRIES)) u_dawc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word),
    .pready      (pready)
);

`default_nettype wire
